// ----- hdl/mhpq_pkg.sv -----
// types and codes shared by the heap queue modules
package mhpq_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 16;
    localparam int POS_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_POP    = 2'd2,
        REQ_NOP    = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]            req_type;
        logic [VALUE_BITS-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] out_value;
        logic [POS_BITS-1:0]   final_position;
        logic [CNT_BITS-1:0]   fill_count;
    } out_item_t;

endpackage

// ----- hdl/mhpq_ram.sv -----
// generic single-port-write, single-read ram with registered read
module mhpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/max_heap_priority_queue_top.sv -----
// top level of the binary max-heap priority queue
// One item at a time; one result item per request. The heap lives in a single
// ram with registered read, and a sequencer walks it one read at a time. Insert
// sifts the new value up level by level. Pop reads the root and the last entry
// and sifts down. Remove scans the store entry by entry, fetches the last entry
// and, unless the hole is the root, its parent, and then sifts up or down as
// above. The next item is accepted once the sequencer is idle and the result
// register is free again; no clearing pass is needed.
module max_heap_priority_queue_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  mhpq_pkg::in_item_t  in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output mhpq_pkg::out_item_t out_item
);
    import mhpq_pkg::*;

    localparam int AW = POS_BITS;
    localparam int CW = CNT_BITS;

    typedef enum logic [4:0] {
        S_IDLE, S_INS_W, S_UP_RD, S_UP_RD2, S_UP_CMP,
        S_SCAN, S_SCAN_CHK, S_RM_LAST, S_RM_LAST2, S_RM_PAR, S_RM_PAR2,
        S_POP_ROOT, S_POP_ROOT2, S_POP_LAST, S_POP_LAST2,
        S_DN_L, S_DN_L2, S_DN_R, S_DN_R2, S_DN_CMP, S_DONE
    } state_t;

    state_t state_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] idx_reg;      // position of the moving element
    logic [AW-1:0] aux_reg;      // parent or child index
    logic [VALUE_BITS-1:0] mv_reg;   // moving value
    logic [VALUE_BITS-1:0] key_reg;
    logic [VALUE_BITS-1:0] lv_reg;
    logic [CW-1:0] scan_reg;
    logic [1:0] req_reg;
    logic out_valid_reg;
    out_item_t out_reg;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [VALUE_BITS-1:0] wdata, rdata;

    mhpq_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // child indexes one bit wider than the count so that overflow beyond the store is seen
    logic [CW:0] lchild, rchild;
    assign lchild = (CW + 1)'({idx_reg, 1'b1});
    assign rchild = (CW + 1)'({idx_reg, 1'b0}) + (CW + 1)'(2);

    logic accept;
    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    logic [AW-1:0] parent;
    assign parent = (idx_reg - AW'(1)) >> 1;

    // ram control
    always_comb
    begin
        we = 1'b0;
        waddr = idx_reg;
        wdata = mv_reg;
        raddr = aux_reg;
        case (state_reg)
            S_INS_W: we = 1'b1;
            S_UP_CMP:
            begin
                // parent value moves down into the hole
                we = (rdata < mv_reg);
                wdata = rdata;
            end
            S_DN_R: raddr = rchild[AW-1:0];  // right child read overlaps the left compare
            S_DN_CMP:
            begin
                we = 1'b1;
                wdata = key_reg;  // larger child moves up
            end
            S_SCAN: raddr = scan_reg[AW-1:0];
            S_DONE:
            begin
                we = (req_reg != REQ_NOP) && (out_reg.status == ST_OK)
                     && (out_reg.fill_count != '0 || req_reg == REQ_INSERT);
            end
            default: ;
        endcase
    end

    logic [CW-1:0] last_c;
    assign last_c = cnt_reg - CW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg <= in_item.req_type;
                        key_reg <= in_item.value;
                        mv_reg <= in_item.value;
                        out_reg.final_position <= '0;
                        case (req_t'(in_item.req_type))
                            REQ_INSERT:
                            begin
                                if (cnt_reg == CW'(DEPTH))
                                begin
                                    out_reg.status <= ST_FULL;
                                    out_reg.out_value <= '0;
                                    out_reg.fill_count <= cnt_reg;
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    idx_reg <= cnt_reg[AW-1:0];
                                    out_reg.status <= ST_OK;
                                    out_reg.out_value <= in_item.value;
                                    cnt_reg <= cnt_reg + CW'(1);
                                    out_reg.fill_count <= cnt_reg + CW'(1);
                                    state_reg <= S_UP_RD;
                                end
                            end
                            REQ_REMOVE, REQ_POP:
                            begin
                                out_reg.out_value <= '0;
                                out_reg.fill_count <= cnt_reg;
                                if (cnt_reg == '0)
                                begin
                                    out_reg.status <= ST_EMPTY;
                                    state_reg <= S_DONE;
                                end
                                else if (in_item.req_type == REQ_REMOVE)
                                begin
                                    out_reg.status <= ST_OK;
                                    scan_reg <= '0;
                                    state_reg <= S_SCAN;
                                end
                                else
                                begin
                                    out_reg.status <= ST_OK;
                                    aux_reg <= '0;
                                    state_reg <= S_POP_ROOT;
                                end
                            end
                            default:
                            begin
                                out_reg.status <= ST_OK;
                                out_reg.out_value <= '0;
                                out_reg.fill_count <= cnt_reg;
                                state_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                // sift-up: hole at idx_reg, value mv_reg
                S_UP_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        aux_reg <= parent;
                        state_reg <= S_UP_RD2;
                    end
                end
                S_UP_RD2: state_reg <= S_UP_CMP;
                S_UP_CMP:
                begin
                    if (rdata < mv_reg)
                    begin
                        idx_reg <= aux_reg;
                        state_reg <= S_UP_RD;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_INS_W: state_reg <= S_DONE;
                S_SCAN:
                begin
                    state_reg <= S_SCAN_CHK;
                end
                S_SCAN_CHK:
                begin
                    if (rdata == key_reg)
                    begin
                        idx_reg <= scan_reg[AW-1:0];
                        out_reg.out_value <= key_reg;
                        cnt_reg <= last_c;
                        out_reg.fill_count <= last_c;
                        out_reg.final_position <= scan_reg[AW-1:0];
                        if (scan_reg == last_c)
                        begin
                            req_reg <= REQ_NOP;  // nothing to write back
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            aux_reg <= last_c[AW-1:0];
                            state_reg <= S_RM_LAST;
                        end
                    end
                    else if (scan_reg == last_c)
                    begin
                        out_reg.status <= ST_NOT_FOUND;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + CW'(1);
                        state_reg <= S_SCAN;
                    end
                end
                S_RM_LAST: state_reg <= S_RM_LAST2;
                S_RM_LAST2:
                begin
                    mv_reg <= rdata;
                    if (idx_reg == '0)
                    begin
                        state_reg <= S_DN_L;
                    end
                    else
                    begin
                        aux_reg <= parent;
                        state_reg <= S_RM_PAR;
                    end
                end
                S_RM_PAR: state_reg <= S_RM_PAR2;
                S_RM_PAR2:
                begin
                    state_reg <= (mv_reg > rdata) ? S_UP_RD : S_DN_L;
                end
                S_POP_ROOT: state_reg <= S_POP_ROOT2;
                S_POP_ROOT2:
                begin
                    out_reg.out_value <= rdata;
                    cnt_reg <= last_c;
                    out_reg.fill_count <= last_c;
                    idx_reg <= '0;
                    aux_reg <= last_c[AW-1:0];
                    state_reg <= (last_c == '0) ? S_DONE : S_POP_LAST;
                    if (last_c == '0)
                    begin
                        req_reg <= REQ_NOP;
                    end
                end
                S_POP_LAST: state_reg <= S_POP_LAST2;
                S_POP_LAST2:
                begin
                    mv_reg <= rdata;
                    state_reg <= S_DN_L;
                end
                // sift-down: hole at idx_reg, value mv_reg
                S_DN_L:
                begin
                    if (lchild >= (CW + 1)'(cnt_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        aux_reg <= lchild[AW-1:0];
                        state_reg <= S_DN_L2;
                    end
                end
                S_DN_L2: state_reg <= S_DN_R;
                S_DN_R:
                begin
                    lv_reg <= rdata;
                    key_reg <= (rdata > mv_reg) ? rdata : mv_reg;
                    if (rchild < (CW + 1)'(cnt_reg))
                    begin
                        aux_reg <= rchild[AW-1:0];
                        state_reg <= S_DN_R2;
                    end
                    else
                    begin
                        state_reg <= (rdata > mv_reg) ? S_DN_CMP : S_DONE;
                    end
                end
                S_DN_R2:
                begin
                    if (rdata > key_reg)
                    begin
                        key_reg <= rdata;
                        state_reg <= S_DN_CMP;
                    end
                    else if (lv_reg > mv_reg)
                    begin
                        aux_reg <= lchild[AW-1:0];
                        state_reg <= S_DN_CMP;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DN_CMP:
                begin
                    idx_reg <= aux_reg;
                    state_reg <= S_DN_L;
                end
                S_DONE:
                begin
                    if (req_reg != REQ_NOP && out_reg.status == ST_OK)
                    begin
                        out_reg.final_position <= idx_reg;
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/mhpq_checker.sv -----
// port-level checks for the heap queue, bound to the top level
module mhpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input mhpq_pkg::in_item_t  in_item,
    input logic                out_valid,
    input logic                out_stall,
    input mhpq_pkg::out_item_t out_item
);
    import mhpq_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken while busy");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != ST_OK |-> out_item.out_value == '0)
        else $error("error result carries a value");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.fill_count <= CNT_BITS'(DEPTH))
        else $error("fill count out of range");
endmodule

bind max_heap_priority_queue_top mhpq_checker u_chk (.*);

// ----- sim/tb.sv -----
// testbench for the max-heap priority queue: scoreboard against a behavioral heap
module tb;
    import mhpq_pkg::*;

    localparam int HEAP_DEPTH = 64;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;

    // behavioral heap and expected results
    logic [15:0] shadow_heap [HEAP_DEPTH];
    int unsigned shadow_count = 0;
    out_item_t pending_results [$];

    int mismatches = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    bit sender_idles = 1'b1;
    bit receiver_idles = 1'b1;
    bit hold_off = 1'b0;
    int n_insert = 0, n_remove = 0, n_pop = 0, n_error = 0;

    always #1 clk = ~clk;

    max_heap_priority_queue_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
        .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
    );

    function automatic void swap_entries(int unsigned a, int unsigned b);
        logic [15:0] t;
        t = shadow_heap[a];
        shadow_heap[a] = shadow_heap[b];
        shadow_heap[b] = t;
    endfunction

    function automatic int unsigned bubble_up(int unsigned i);
        int unsigned p;
        while (i != 0)
        begin
            p = (i - 1) / 2;
            if (shadow_heap[i] <= shadow_heap[p])
                break;
            swap_entries(i, p);
            i = p;
        end
        return i;
    endfunction

    function automatic int unsigned bubble_down(int unsigned i, int unsigned cnt);
        int unsigned l, r, m;
        forever
        begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            m = i;
            if (l >= cnt)
                break;
            if (shadow_heap[l] > shadow_heap[m])
                m = l;
            if (r < cnt && shadow_heap[r] > shadow_heap[m])
                m = r;
            if (m == i)
                break;
            swap_entries(i, m);
            i = m;
        end
        return i;
    endfunction

    // apply one request to the shadow heap and return the expected result
    function automatic out_item_t heap_request(in_item_t req);
        out_item_t res;
        int unsigned i, last;
        res = '0;
        case (req_t'(req.req_type))
            REQ_INSERT:
            begin
                if (shadow_count >= HEAP_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_heap[shadow_count] = req.value;
                    shadow_count++;
                    res.final_position = POS_BITS'(bubble_up(shadow_count - 1));
                    res.out_value = req.value;
                end
            end
            REQ_REMOVE:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    i = 0;
                    while (i < shadow_count && shadow_heap[i] != req.value)
                        i++;
                    if (i == shadow_count)
                        res.status = ST_NOT_FOUND;
                    else
                    begin
                        last = shadow_count - 1;
                        res.out_value = req.value;
                        shadow_heap[i] = shadow_heap[last];
                        shadow_count = last;
                        res.final_position = POS_BITS'(i);
                        if (i < last)
                        begin
                            if (i != 0 && shadow_heap[i] > shadow_heap[(i - 1) / 2])
                                res.final_position = POS_BITS'(bubble_up(i));
                            else
                                res.final_position = POS_BITS'(bubble_down(i, shadow_count));
                        end
                    end
                end
            end
            REQ_POP:
            begin
                if (shadow_count == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.out_value = shadow_heap[0];
                    shadow_count--;
                    shadow_heap[0] = shadow_heap[shadow_count];
                    res.final_position = POS_BITS'(bubble_down(0, shadow_count));
                end
            end
            default: ;
        endcase
        res.fill_count = CNT_BITS'(shadow_count);
        return res;
    endfunction

    // send one item; predicts at the accepting edge, valid stays up for the next call
    task automatic send_item(req_t kind, logic [15:0] val);
        int gap;
        out_item_t exp_res;
        if (sender_idles && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= '{req_type: kind, value: val};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        exp_res = heap_request('{req_type: kind, value: val});
        pending_results.push_back(exp_res);
        if (exp_res.status != ST_OK)
            n_error++;
        case (kind)
            REQ_INSERT: n_insert++;
            REQ_REMOVE: n_remove++;
            REQ_POP: n_pop++;
            default: ;
        endcase
    endtask

    // pick a value currently in the heap, or a random one if empty
    function automatic logic [15:0] stored_value();
        if (shadow_count == 0)
            return 16'($urandom);
        return shadow_heap[$urandom_range(0, shadow_count - 1)];
    endfunction

    // result checker: compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", out_item);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_item.status !== want.status
                    || out_item.out_value !== want.out_value
                    || out_item.final_position !== want.final_position
                    || out_item.fill_count !== want.fill_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p got %p", want, out_item);
                end
            end
        end
    end

    // receiver stall: random bursts, or one long hold-off
    always @(posedge clk)
    begin
        int burst;
        if (hold_off)
            out_stall <= 1'b1;
        else if (burst > 0)
        begin
            burst--;
            out_stall <= 1'b1;
        end
        else if (receiver_idles && $urandom_range(0, 6) == 0)
        begin
            burst = $urandom_range(1, 15);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d results pending", pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic test_directed();
        send_item(REQ_POP, 16'h0000);          // pop from empty
        send_item(REQ_REMOVE, 16'h1234);       // remove from empty
        send_item(REQ_NOP, 16'hFFFF);          // no-op request
        send_item(REQ_INSERT, 16'h0000);
        send_item(REQ_INSERT, 16'hFFFF);
        send_item(REQ_INSERT, 16'h5555);
        send_item(REQ_INSERT, 16'hAAAA);
        send_item(REQ_INSERT, 16'h5555);       // duplicate value
        send_item(REQ_REMOVE, 16'h7777);       // no match
        send_item(REQ_REMOVE, stored_value()); 
        send_item(REQ_REMOVE, shadow_heap[shadow_count - 1]); // last entry
        send_item(REQ_POP, 16'h0);
        send_item(REQ_POP, 16'h0);
        send_item(REQ_POP, 16'h0);
        send_item(REQ_POP, 16'h0);             // pop from the emptied heap
        // fill to capacity, then one insert too many
        while (shadow_count < HEAP_DEPTH)
            send_item(REQ_INSERT, 16'($urandom));
        send_item(REQ_INSERT, 16'hFFFF);
        // remove a leaf entry near the end so the last entry moves into its place
        send_item(REQ_REMOVE, shadow_heap[HEAP_DEPTH - 2]);
    endtask

    // receiver holds off while the sender keeps pushing
    task automatic test_backpressure();
        int held;
        hold_off = 1'b1;
        fork
            begin
                held = 0;
                while (held < 400)
                begin
                    @(posedge clk);
                    held++;
                end
                hold_off = 1'b0;
            end
            repeat (8) send_item(req_t'($urandom_range(0, 2)), stored_value());
        join
    endtask

    task automatic test_random(int count);
        int k;
        int pick;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_item(REQ_INSERT, 16'($urandom));
            else if (pick < 65)
                send_item(REQ_REMOVE, stored_value());
            else if (pick < 72)
                send_item(REQ_REMOVE, 16'($urandom));
            else if (pick < 97)
                send_item(REQ_POP, 16'($urandom));
            else
                send_item(REQ_NOP, 16'($urandom));
        end
    endtask

    task automatic test_drain_and_refill();
        while (shadow_count > 0)
            send_item(REQ_POP, 16'($urandom));
        send_item(REQ_POP, 16'h0);
        test_random(150);
    endtask

    initial
    begin
        int settle;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(1400);
        test_drain_and_refill();
        // last stretch with no idling on either side
        sender_idles = 1'b0;
        receiver_idles = 1'b0;
        test_random(400);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        for (settle = 0; settle < 200; settle++)
            @(posedge clk);
        $display("covered %0d inserts, %0d removes, %0d pops, %0d error results",
                 n_insert, n_remove, n_pop, n_error);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- files.f -----
hdl/mhpq_pkg.sv
hdl/mhpq_ram.sv
hdl/max_heap_priority_queue_top.sv
hdl/mhpq_checker.sv
sim/tb.sv
